// ----- sv/wptd_pkg.sv -----
// shared constants, types and helpers for the window polarity threshold detector
package wptd_pkg;

  localparam int MAX_WINDOW  = 256;
  localparam int ADDR_W      = $clog2(MAX_WINDOW);
  localparam int CNT_W       = 9;
  localparam int THR_W       = 17;
  localparam int FRAC_W      = 16;
  localparam int PROD_W      = THR_W + CNT_W;
  localparam int SAMPLE_W    = 32;
  localparam int TALLY_W     = 32;
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 17;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_WINDOW_LENGTH = 4'd0,
    REG_WARMUP_FILL   = 4'd1,
    REG_BULL_LEVEL    = 4'd2,
    REG_BEAR_LEVEL    = 4'd3
  } reg_index_t;

  localparam logic [CNT_W-1:0] WINDOW_LENGTH_RST = 9'd64;
  localparam logic [CNT_W-1:0] WARMUP_FILL_RST   = 9'd8;
  localparam logic [THR_W-1:0] BULL_LEVEL_RST    = 17'd39322;
  localparam logic [THR_W-1:0] BEAR_LEVEL_RST    = 17'd26214;

  typedef struct packed {
    logic [CNT_W-1:0] window_length;
    logic [CNT_W-1:0] warmup_fill;
    logic [THR_W-1:0] bull_level;
    logic [THR_W-1:0] bear_level;
  } cfg_t;

  typedef struct packed {
    logic [CNT_W-1:0] positive_count;
    logic [CNT_W-1:0] window_fill;
  } window_stat_t;

  // first declared member lands in the highest bits
  typedef struct packed {
    logic [TALLY_W-1:0] total_samples;
    logic [TALLY_W-1:0] bearish_event_count;
    logic [TALLY_W-1:0] bullish_event_count;
    logic               bearish_event;
    logic               bullish_event;
    logic               bear_flag;
    logic               bull_flag;
    logic               warming_up;
    logic [CNT_W-1:0]   window_fill;
    logic [CNT_W-1:0]   positive_count;
  } result_t;

  localparam int RESULT_W   = $bits(result_t);
  localparam int OUT_DATA_W = ((RESULT_W + 7) / 8) * 8;

  function automatic logic [CNT_W-1:0] effective_window(input logic [CNT_W-1:0] len);
    logic [CNT_W-1:0] w;
    w = len;
    if (len == '0) begin
      w = CNT_W'(1);
    end else if (len > CNT_W'(MAX_WINDOW)) begin
      w = CNT_W'(MAX_WINDOW);
    end
    return w;
  endfunction

endpackage

// ----- sv/wptd_ram.sv -----
// generic single-write, single-read ram with registered read data
module wptd_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/wptd_window.sv -----
// sign bit ring, running positive count and fill level, first pipeline stage
module wptd_window (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            clear,
  input  logic [wptd_pkg::CNT_W-1:0]      win,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [wptd_pkg::SAMPLE_W-1:0]   in_sample,
  output logic                            stat_valid,
  input  logic                            stat_ready,
  output wptd_pkg::window_stat_t          stat
);
  import wptd_pkg::*;

  logic [ADDR_W-1:0] wp;
  logic [ADDR_W-1:0] wp_next;
  logic [CNT_W-1:0]  fill;
  logic [CNT_W-1:0]  fill_next;
  logic [CNT_W-1:0]  running;
  logic [CNT_W-1:0]  running_next;
  logic              bypass;
  logic              bypass_bit;
  logic              ram_bit;
  logic              old_bit;
  logic              new_bit;
  logic              accept;
  logic [CNT_W-1:0]  wp_inc;

  assign in_ready = !stat_valid || stat_ready;
  assign accept   = in_valid && in_ready;
  assign new_bit  = (in_sample != '0) && !in_sample[SAMPLE_W-1];

  // slots beyond the fill level were never written since the last clear
  assign old_bit = (fill == win) ? (bypass ? bypass_bit : ram_bit) : 1'b0;

  assign wp_inc       = CNT_W'(wp) + CNT_W'(1);
  assign running_next = running - CNT_W'(old_bit) + CNT_W'(new_bit);
  assign fill_next    = (fill < win) ? fill + CNT_W'(1) : fill;

  always_comb begin
    wp_next = wp;
    if (clear) begin
      wp_next = '0;
    end else if (accept) begin
      wp_next = (wp_inc >= win) ? '0 : wp_inc[ADDR_W-1:0];
    end
  end

  wptd_ram #(
    .WIDTH (1),
    .DEPTH (MAX_WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (accept),
    .waddr (wp),
    .wdata (new_bit),
    .raddr (wp_next),
    .rdata (ram_bit)
  );

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      wp         <= '0;
      fill       <= '0;
      running    <= '0;
      bypass     <= 1'b0;
      stat_valid <= 1'b0;
    end else begin
      wp     <= wp_next;
      bypass <= accept && (wp_next == wp);
      if (accept) begin
        fill    <= fill_next;
        running <= running_next;
      end
      if (in_ready) begin
        stat_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    bypass_bit <= new_bit;
    if (accept) begin
      stat.positive_count <= running_next;
      stat.window_fill    <= fill_next;
    end
  end

  a_fill_in_window: assert property (@(posedge clk) disable iff (rst) fill <= win)
    else $error("fill level beyond window length");
  a_count_in_fill: assert property (@(posedge clk) disable iff (rst) running <= fill)
    else $error("positive count beyond fill level");
  a_wp_in_window: assert property (@(posedge clk) disable iff (rst)
    CNT_W'(wp) < win)
    else $error("write position outside window");
  a_stat_tracks: assert property (@(posedge clk) disable iff (rst)
    accept && !clear |=> stat_valid && stat.window_fill == fill)
    else $error("stage register out of step with fill level");

endmodule

// ----- sv/wptd_eval.sv -----
// exact fraction compare, edge events and tallies, result register
module wptd_eval (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         clear,
  input  wptd_pkg::cfg_t               cfg,
  input  logic                         stat_valid,
  output logic                         stat_ready,
  input  wptd_pkg::window_stat_t       stat,
  output logic                         out_valid,
  input  logic                         out_ready,
  output wptd_pkg::result_t            result
);
  import wptd_pkg::*;

  logic               accept;
  logic               warming;
  logic [PROD_W-1:0]  scaled;
  logic [PROD_W-1:0]  bull_prod;
  logic [PROD_W-1:0]  bear_prod;
  logic               bull;
  logic               bear;
  logic               bull_ev;
  logic               bear_ev;
  logic               last_bull;
  logic               last_bear;
  logic [TALLY_W-1:0] bull_tally;
  logic [TALLY_W-1:0] bear_tally;
  logic [TALLY_W-1:0] sample_tally;
  logic [TALLY_W-1:0] bull_tally_next;
  logic [TALLY_W-1:0] bear_tally_next;
  logic [TALLY_W-1:0] sample_tally_next;

  assign stat_ready = !out_valid || out_ready;
  assign accept     = stat_valid && stat_ready;

  assign warming   = stat.window_fill < cfg.warmup_fill;
  assign scaled    = PROD_W'({stat.positive_count, {FRAC_W{1'b0}}});
  assign bull_prod = PROD_W'(cfg.bull_level) * PROD_W'(stat.window_fill);
  assign bear_prod = PROD_W'(cfg.bear_level) * PROD_W'(stat.window_fill);
  assign bull      = !warming && (scaled >= bull_prod);
  assign bear      = !warming && (scaled <= bear_prod);
  assign bull_ev   = bull && !last_bull;
  assign bear_ev   = bear && !last_bear;

  assign bull_tally_next   = bull_tally + TALLY_W'(bull_ev);
  assign bear_tally_next   = bear_tally + TALLY_W'(bear_ev);
  assign sample_tally_next = sample_tally + TALLY_W'(1);

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      last_bull    <= 1'b0;
      last_bear    <= 1'b0;
      bull_tally   <= '0;
      bear_tally   <= '0;
      sample_tally <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (accept) begin
        if (!warming) begin
          last_bull <= bull;
          last_bear <= bear;
        end
        bull_tally   <= bull_tally_next;
        bear_tally   <= bear_tally_next;
        sample_tally <= sample_tally_next;
      end
      if (stat_ready) begin
        out_valid <= stat_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result.positive_count      <= stat.positive_count;
      result.window_fill         <= stat.window_fill;
      result.warming_up          <= warming;
      result.bull_flag           <= bull;
      result.bear_flag           <= bear;
      result.bullish_event       <= bull_ev;
      result.bearish_event       <= bear_ev;
      result.bullish_event_count <= bull_tally_next;
      result.bearish_event_count <= bear_tally_next;
      result.total_samples       <= sample_tally_next;
    end
  end

  a_bull_event_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid && result.bullish_event |-> result.bull_flag)
    else $error("bullish event without bullish flag");
  a_bear_event_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid && result.bearish_event |-> result.bear_flag)
    else $error("bearish event without bearish flag");
  a_warming_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && result.warming_up |-> !result.bull_flag && !result.bear_flag)
    else $error("flags raised while warming up");
  a_event_repeat: assert property (@(posedge clk) disable iff (rst || clear)
    accept && !warming && bull |=> !bull_ev || !accept)
    else $error("bullish event repeated without falling edge");

endmodule

// ----- sv/window_polarity_threshold_detector_top.sv -----
// top level: configuration registers, stream ports and the two pipeline stages
// stages: window stage register, then result register; throughput: one
// transaction per cycle unless m_tready stalls the pipeline, the sign ring ram
// is read one step ahead of the write pointer, forwarding for a one-sample window
// reset: synchronous, loads default registers and clears counts and tallies;
// writing a defined register clears the same state; the ring needs no clearing pass
module window_polarity_threshold_detector_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [wptd_pkg::SAMPLE_W-1:0]       s_tdata,   // bias_sample
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // positive_count, window_fill, warming_up, bull flag, bear flag, bullish_event,
  // bearish_event, bullish_event_count, bearish_event_count, total_samples, zero pad
  output logic [wptd_pkg::OUT_DATA_W-1:0]     m_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [wptd_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [wptd_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import wptd_pkg::*;

  cfg_t         cfg;
  logic         cfg_write;
  logic         clear;
  logic         stat_valid;
  logic         stat_ready;
  window_stat_t stat;
  result_t      result;
  logic [CNT_W-1:0] win;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign clear     = cfg_write && ((cfg_index == REG_WINDOW_LENGTH)
                                || (cfg_index == REG_WARMUP_FILL)
                                || (cfg_index == REG_BULL_LEVEL)
                                || (cfg_index == REG_BEAR_LEVEL));
  assign win       = effective_window(cfg.window_length);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_length <= WINDOW_LENGTH_RST;
      cfg.warmup_fill   <= WARMUP_FILL_RST;
      cfg.bull_level    <= BULL_LEVEL_RST;
      cfg.bear_level    <= BEAR_LEVEL_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_WINDOW_LENGTH: cfg.window_length <= cfg_data[CNT_W-1:0];
        REG_WARMUP_FILL:   cfg.warmup_fill   <= cfg_data[CNT_W-1:0];
        REG_BULL_LEVEL:    cfg.bull_level    <= cfg_data[THR_W-1:0];
        REG_BEAR_LEVEL:    cfg.bear_level    <= cfg_data[THR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  wptd_window u_window (
    .clk        (clk),
    .rst        (rst),
    .clear      (clear),
    .win        (win),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_sample  (s_tdata),
    .stat_valid (stat_valid),
    .stat_ready (stat_ready),
    .stat       (stat)
  );

  wptd_eval u_eval (
    .clk        (clk),
    .rst        (rst),
    .clear      (clear),
    .cfg        (cfg),
    .stat_valid (stat_valid),
    .stat_ready (stat_ready),
    .stat       (stat),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .result     (result)
  );

  assign m_tdata = OUT_DATA_W'(result);

endmodule

// ----- verif/testbench.sv -----
// self-checking testbench for the window polarity threshold detector top level
module testbench;
  import wptd_pkg::*;

  localparam int QUIET_LIMIT  = 2000;
  localparam int SETTLE       = 4;
  localparam int RANDOM_ITEMS = 1700;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    logic [CFG_INDEX_W-1:0] idx;
    logic [CFG_DATA_W-1:0]  val;
    logic [SAMPLE_W-1:0]    sample;
    bit                     known;
    result_t                want;
  } plan_row_t;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [SAMPLE_W-1:0]    s_tdata;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_DATA_W-1:0]  m_tdata;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  window_polarity_threshold_detector_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predictor copy of the registers and the window state
  logic [CNT_W-1:0]      cfg_win;
  logic [CNT_W-1:0]      cfg_min;
  logic [THR_W-1:0]      cfg_bull;
  logic [THR_W-1:0]      cfg_bear;
  logic [MAX_WINDOW-1:0] ring_bits;
  logic [ADDR_W-1:0]     ring_pos;
  logic [CNT_W-1:0]      ring_fill;
  logic [CNT_W-1:0]      pos_total;
  logic                  prev_bull;
  logic                  prev_bear;
  logic [TALLY_W-1:0]    bull_events;
  logic [TALLY_W-1:0]    bear_events;
  logic [TALLY_W-1:0]    sample_count;

  result_t   pending_results[$];
  plan_row_t plan[$];

  int  fail_count;
  int  samples_sent;
  int  writes_done;
  int  results_checked;
  int  quiet_cycles;
  int  stall_left;
  bit  send_busy;
  bit  recv_busy;

  function automatic logic [CNT_W-1:0] live_window();
    if (cfg_win == '0) return CNT_W'(1);
    if (cfg_win > CNT_W'(MAX_WINDOW)) return CNT_W'(MAX_WINDOW);
    return cfg_win;
  endfunction

  task automatic clear_window();
    ring_bits    = '0;
    ring_pos     = '0;
    ring_fill    = '0;
    pos_total    = '0;
    prev_bull    = 1'b0;
    prev_bear    = 1'b0;
    bull_events  = '0;
    bear_events  = '0;
    sample_count = '0;
  endtask

  task automatic apply_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    unique case (idx)
      REG_WINDOW_LENGTH: cfg_win  = val[CNT_W-1:0];
      REG_WARMUP_FILL:   cfg_min  = val[CNT_W-1:0];
      REG_BULL_LEVEL:    cfg_bull = val[THR_W-1:0];
      REG_BEAR_LEVEL:    cfg_bear = val[THR_W-1:0];
      default: return;
    endcase
    clear_window();
  endtask

  task automatic predict_polarity(input logic [SAMPLE_W-1:0] v, output result_t r);
    logic [CNT_W-1:0] win;
    logic             bit_in;
    logic             warming;
    logic             bull;
    logic             bear;
    logic             bull_ev;
    logic             bear_ev;
    logic [63:0]      scaled;
    win     = live_window();
    bit_in  = ($signed(v) > 0);
    bull    = 1'b0;
    bear    = 1'b0;
    bull_ev = 1'b0;
    bear_ev = 1'b0;
    if ({1'b0, ring_pos} >= win) ring_pos = '0;
    pos_total = pos_total - CNT_W'(ring_bits[ring_pos]) + CNT_W'(bit_in);
    ring_bits[ring_pos] = bit_in;
    if ({1'b0, ring_pos} + 9'd1 >= win) ring_pos = '0;
    else ring_pos = ring_pos + 1'b1;
    if (ring_fill < win) ring_fill = ring_fill + 1'b1;
    warming = (ring_fill < cfg_min);
    if (!warming) begin
      scaled = 64'(pos_total) << FRAC_W;
      bull = (scaled >= 64'(cfg_bull) * 64'(ring_fill));
      bear = (scaled <= 64'(cfg_bear) * 64'(ring_fill));
      if (bull && !prev_bull) begin
        bull_ev = 1'b1;
        bull_events = bull_events + 1'b1;
      end
      if (bear && !prev_bear) begin
        bear_ev = 1'b1;
        bear_events = bear_events + 1'b1;
      end
      prev_bull = bull;
      prev_bear = bear;
    end
    sample_count = sample_count + 1'b1;
    r.positive_count      = pos_total;
    r.window_fill         = ring_fill;
    r.warming_up          = warming;
    r.bull_flag           = bull;
    r.bear_flag           = bear;
    r.bullish_event       = bull_ev;
    r.bearish_event       = bear_ev;
    r.bullish_event_count = bull_events;
    r.bearish_event_count = bear_events;
    r.total_samples       = sample_count;
  endtask

  function automatic int pick_gap(input bit busy);
    int r;
    if (!busy) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [SAMPLE_W-1:0] make_sample(input int pct);
    logic [SAMPLE_W-1:0] v;
    int r;
    r = $urandom_range(0, 99);
    if (r < pct) begin
      v = $urandom & 32'h7fff_ffff;
      if (v == '0 || $urandom_range(0, 31) == 0) v = 32'h7fff_ffff;
    end else begin
      r = $urandom_range(0, 15);
      if (r < 2) v = '0;
      else if (r == 2) v = 32'h8000_0000;
      else v = $urandom | 32'h8000_0000;
    end
    return v;
  endfunction

  function automatic logic [THR_W-1:0] pick_threshold();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return THR_W'(65536);
    if (r < 30) return THR_W'($urandom_range(65537, 131071));
    if (r < 40) return THR_W'($urandom);
    return THR_W'($urandom_range(8000, 58000));
  endfunction

  function automatic plan_row_t sample_row(input logic [SAMPLE_W-1:0] v);
    plan_row_t p;
    p.kind   = ROW_SAMPLE;
    p.idx    = '0;
    p.val    = '0;
    p.sample = v;
    p.known  = 1'b0;
    p.want   = '0;
    return p;
  endfunction

  function automatic plan_row_t write_row(input logic [CFG_INDEX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] val);
    plan_row_t p;
    p      = sample_row('0);
    p.kind = ROW_WRITE;
    p.idx  = idx;
    p.val  = val;
    return p;
  endfunction

  // warming rows right after reset: flags and event tallies still zero
  function automatic plan_row_t known_row(input logic [SAMPLE_W-1:0] v, input int cnt,
                                          input int fill, input int total);
    plan_row_t p;
    p = sample_row(v);
    p.known = 1'b1;
    p.want.positive_count = CNT_W'(cnt);
    p.want.window_fill    = CNT_W'(fill);
    p.want.warming_up     = 1'b1;
    p.want.total_samples  = TALLY_W'(total);
    return p;
  endfunction

  task automatic push_sample(input logic [SAMPLE_W-1:0] v, input bit known, input result_t want);
    int      gap;
    result_t r;
    gap = pick_gap(send_busy);
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    do @(posedge clk); while (!s_tready);
    predict_polarity(v, r);
    pending_results.push_back(known ? want : r);
    samples_sent++;
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, val);
    writes_done++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      fail_count++;
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else begin
      m_tready <= 1'b1;
      stall_left = pick_gap(recv_busy);
    end
  end

  always @(posedge clk) begin : check_results
    result_t got;
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = result_t'(m_tdata[RESULT_W-1:0]);
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        check_field("positive_count", 32'(want.positive_count), 32'(got.positive_count));
        check_field("window_fill", 32'(want.window_fill), 32'(got.window_fill));
        check_field("warming_up", 32'(want.warming_up), 32'(got.warming_up));
        check_field("bull_flag", 32'(want.bull_flag), 32'(got.bull_flag));
        check_field("bear_flag", 32'(want.bear_flag), 32'(got.bear_flag));
        check_field("bullish_event", 32'(want.bullish_event), 32'(got.bullish_event));
        check_field("bearish_event", 32'(want.bearish_event), 32'(got.bearish_event));
        check_field("bullish_event_count", want.bullish_event_count, got.bullish_event_count);
        check_field("bearish_event_count", want.bearish_event_count, got.bearish_event_count);
        check_field("total_samples", want.total_samples, got.total_samples);
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin : stimulus
    int                  rand_items;
    int                  phase_len;
    int                  seg_left;
    int                  pct;
    int                  r;
    logic [CNT_W-1:0]    wl;
    logic [CNT_W-1:0]    eff;
    result_t             none;
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    fail_count = 0;
    none       = '0;
    send_busy  = 1'b1;
    recv_busy  = 1'b1;
    cfg_win    = WINDOW_LENGTH_RST;
    cfg_min    = WARMUP_FILL_RST;
    cfg_bull   = BULL_LEVEL_RST;
    cfg_bear   = BEAR_LEVEL_RST;
    clear_window();

    // defaults after reset, then each special case in turn
    plan.push_back(known_row(32'h0000_0001, 1, 1, 1));
    plan.push_back(known_row(32'h0000_0000, 1, 2, 2));
    plan.push_back(known_row(32'h8000_0000, 1, 3, 3));
    plan.push_back(known_row(32'h7fff_ffff, 2, 4, 4));
    plan.push_back(known_row(32'hffff_ffff, 2, 5, 5));
    plan.push_back(sample_row(32'h0000_0005));
    plan.push_back(sample_row(32'h1234_5678));
    plan.push_back(sample_row(32'h0000_0001));
    plan.push_back(sample_row(32'hdead_beef));
    plan.push_back(write_row(REG_WINDOW_LENGTH, 17'd0));
    plan.push_back(write_row(REG_WARMUP_FILL, 17'd0));
    plan.push_back(sample_row(32'h0000_0001));
    plan.push_back(sample_row(32'h0000_0000));
    plan.push_back(sample_row(32'h0000_0001));
    plan.push_back(write_row(REG_WINDOW_LENGTH, 17'h1ffff));
    plan.push_back(sample_row(32'h0000_0001));
    plan.push_back(sample_row(32'h0000_0000));
    plan.push_back(write_row(REG_WARMUP_FILL, 17'd300));
    plan.push_back(sample_row(32'h7fff_ffff));
    plan.push_back(write_row(REG_WARMUP_FILL, 17'd0));
    plan.push_back(write_row(REG_BULL_LEVEL, 17'h1ffff));
    plan.push_back(write_row(REG_BEAR_LEVEL, 17'h1ffff));
    plan.push_back(write_row(REG_WINDOW_LENGTH, 17'd4));
    plan.push_back(sample_row(32'h0000_0001));
    plan.push_back(sample_row(32'h8000_0000));
    plan.push_back(sample_row(32'h0000_0001));
    plan.push_back(write_row(REG_BULL_LEVEL, 17'd0));
    plan.push_back(write_row(REG_BEAR_LEVEL, 17'd0));
    plan.push_back(sample_row(32'h0000_0000));
    plan.push_back(sample_row(32'h0000_0001));
    plan.push_back(sample_row(32'hffff_ffff));
    plan.push_back(write_row(REG_BULL_LEVEL, 17'd65536));
    plan.push_back(write_row(REG_BEAR_LEVEL, 17'd65536));
    plan.push_back(sample_row(32'h0000_0001));
    plan.push_back(sample_row(32'h0000_0000));
    // unused register index leaves the window intact
    plan.push_back(write_row(4'hf, 17'h15555));
    plan.push_back(sample_row(32'h0000_0001));

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) write_reg(plan[i].idx, plan[i].val);
      else push_sample(plan[i].sample, plan[i].known, plan[i].want);
    end

    rand_items = 0;
    pct        = 50;
    while (rand_items < RANDOM_ITEMS) begin
      send_busy = ($urandom_range(0, 3) != 0);
      recv_busy = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) == 0) begin
        write_reg(CFG_INDEX_W'($urandom_range(4, 15)), CFG_DATA_W'($urandom));
      end
      if ($urandom_range(0, 99) < 70) begin
        r = $urandom_range(0, 99);
        if (r < 10) wl = '0;
        else if (r < 20) wl = CNT_W'(256);
        else if (r < 28) wl = CNT_W'($urandom_range(257, 511));
        else if (r < 70) wl = CNT_W'($urandom_range(1, 16));
        else wl = CNT_W'($urandom_range(17, 255));
        write_reg(REG_WINDOW_LENGTH, {8'($urandom), wl});
      end
      if ($urandom_range(0, 99) < 60) begin
        eff = live_window();
        r = $urandom_range(0, 99);
        if (r < 10) wl = '0;
        else if (r < 20) wl = CNT_W'($urandom_range(int'(eff) + 1, 511));
        else wl = CNT_W'($urandom_range(0, int'(eff)));
        write_reg(REG_WARMUP_FILL, {8'($urandom), wl});
      end
      if ($urandom_range(0, 99) < 50) write_reg(REG_BULL_LEVEL, pick_threshold());
      if ($urandom_range(0, 99) < 50) write_reg(REG_BEAR_LEVEL, pick_threshold());
      phase_len = $urandom_range(30, 150);
      seg_left  = 0;
      repeat (phase_len) begin
        if (seg_left == 0) begin
          r = $urandom_range(0, 99);
          if (r < 10) pct = 0;
          else if (r < 20) pct = 100;
          else pct = $urandom_range(0, 100);
          seg_left = $urandom_range(6, 24);
        end
        seg_left--;
        push_sample(make_sample(pct), 1'b0, none);
        rand_items++;
      end
    end

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE * 4) @(posedge clk);

    $display("summary: %0d samples sent, %0d register writes, %0d results compared",
             samples_sent, writes_done, results_checked);
    $display("summary: windows from one to full depth, thresholds from zero past one");
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
